// ----- rtl/core/icr2d_pkg.sv -----
// Shared widths, codes and saturation helper for the 2D collision response block.
`default_nettype none

package icr2d_pkg;

    // Register file of the configuration port.
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 31;

    localparam logic [CfgIdxW-1:0] REG_BODY_MASS   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_RESTITUTION = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_SLOP_DEPTH  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_CORR_FRAC   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_COLL_TRIG   = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_BODY_ACTIVE = 3'd5;

    // Item function codes.
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_COLLIDE = 1'b1;

    // Fixed point types.
    typedef logic signed [31:0] t_q16;
    typedef logic signed [15:0] t_q14;
    typedef logic        [30:0] t_umag;

    // Clamp a wide signed value to the 32-bit signed range.
    function automatic t_q16 f_sat32(input logic signed [73:0] v);
        t_q16 res;
        if (&v[73:31] || ~|v[73:31]) begin
            res = v[31:0];
        end else if (v[73]) begin
            res = 32'sh8000_0000;
        end else begin
            res = 32'sh7fff_ffff;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/impulse_collision_response_2d.sv -----
// Top level of the 2D impulse collision response block with its shared arithmetic unit.
`default_nettype none

// One rigid body's velocity is kept here. A load item writes it, and its result is
// offered in the cycle after acceptance; a pass-through collision answers the same
// way. A collision runs through one shared shift-add multiplier and one restoring
// divider under a sequencer. Against a static partner it takes eight products;
// against a dynamic one it takes two more products and two quotients. A separating
// contact skips the last three products (static) or the last four products and
// the second quotient (dynamic). The result is then offered until taken, and the
// block is ready again in the cycle after that; it takes no new item before that.
// Configuration writes are taken at any time but belong to idle periods.
module impulse_collision_response_2d (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [icr2d_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  wire  [icr2d_pkg::CfgDataW-1:0]    i_cfg_data,
    input  wire                               i_valid,
    output logic                              o_ready,
    input  wire                               i_func,
    input  wire  signed [15:0]                i_normal_x,
    input  wire  signed [15:0]                i_normal_y,
    input  wire  [30:0]                       i_depth,
    input  wire                               i_contact_is_trigger,
    input  wire                               i_other_dynamic,
    input  wire  [30:0]                       i_other_mass,
    input  wire  signed [31:0]                i_other_vel_x,
    input  wire  signed [31:0]                i_other_vel_y,
    input  wire  signed [31:0]                i_load_vel_x,
    input  wire  signed [31:0]                i_load_vel_y,
    output logic                              o_valid,
    input  wire                               i_ready,
    output logic signed [31:0]                o_pos_dx,
    output logic signed [31:0]                o_pos_dy,
    output logic signed [31:0]                o_vel_x,
    output logic signed [31:0]                o_vel_y,
    output logic                              o_impulse_applied
);
    import icr2d_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CM   = 4'd1;
    localparam logic [3:0] S_CMD  = 4'd2;
    localparam logic [3:0] S_CMV  = 4'd3;
    localparam logic [3:0] S_PX   = 4'd4;
    localparam logic [3:0] S_PY   = 4'd5;
    localparam logic [3:0] S_RX   = 4'd6;
    localparam logic [3:0] S_RY   = 4'd7;
    localparam logic [3:0] S_J    = 4'd8;
    localparam logic [3:0] S_JM   = 4'd9;
    localparam logic [3:0] S_JV   = 4'd10;
    localparam logic [3:0] S_VX   = 4'd11;
    localparam logic [3:0] S_VY   = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    localparam logic [6:0] MulLast = 7'd32;
    localparam logic [6:0] DivLast = 7'd68;

    // Configuration registers.
    logic [30:0] r_body_mass;
    logic [15:0] r_restitution;
    logic [30:0] r_slop;
    logic [15:0] r_frac;
    logic        r_coll_trig;
    logic        r_active;

    // Body state and results.
    t_q16        r_vx, r_vy;
    t_q16        r_pdx, r_pdy;
    logic        r_applied;

    // Latched item.
    t_q14        r_nx, r_ny;
    logic        r_dyn;
    logic [30:0] r_mo;
    logic [31:0] r_msum;
    t_q16        r_vox, r_voy;

    // Sequencer and shared unit.
    logic [3:0]         r_state;
    logic [6:0]         r_cnt;
    logic signed [72:0] r_ma;
    logic [32:0]        r_mb;
    logic signed [72:0] r_acc;
    logic [68:0]        r_dn;
    logic [32:0]        r_rem;
    logic [39:0]        r_q;
    logic [31:0]        r_cm;
    logic [36:0]        r_j;

    logic signed [72:0] n_acc;
    logic signed [72:0] sh_acc;
    logic [33:0]        div_t;
    logic               div_ge;
    logic [32:0]        n_rem;
    logic [39:0]        n_q;
    logic               is_mul, is_div, done, keep_acc;
    logic [3:0]         n_state;
    logic signed [40:0] l_a;
    logic [32:0]        l_b;
    logic [30:0]        c_w, m_w, mo_w;
    logic signed [40:0] neg_van;
    logic signed [32:0] rx_w, ry_w;
    logic               pass_w;

    assign o_ready           = (r_state == S_IDLE);
    assign o_valid           = (r_state == S_OUT);
    assign o_pos_dx          = r_pdx;
    assign o_pos_dy          = r_pdy;
    assign o_vel_x           = r_vx;
    assign o_vel_y           = r_vy;
    assign o_impulse_applied = r_applied;

    // Shared multiplier step: signed multiplicand, multiplier bits taken LSB first,
    // the last bit carries negative weight.
    always_comb begin
        n_acc = r_acc;
        if (r_mb[0]) begin
            n_acc = (r_cnt == MulLast) ? r_acc - r_ma : r_acc + r_ma;
        end
        sh_acc = n_acc >>> 14;
    end

    // Shared divider step, one quotient bit per cycle.
    always_comb begin
        div_t  = {r_rem, r_dn[68]};
        div_ge = (div_t >= {2'b00, r_msum});
        n_rem  = div_ge ? 33'(div_t - {2'b00, r_msum}) : div_t[32:0];
        n_q    = {r_q[38:0], div_ge};
    end

    // Operands taken from the item at acceptance and from the latched item state.
    always_comb begin
        c_w    = (i_depth > r_slop) ? 31'(i_depth - r_slop) : 31'd0;
        m_w    = (r_body_mass == 31'd0) ? 31'd1 : r_body_mass;
        mo_w   = (i_other_mass == 31'd0) ? 31'd1 : i_other_mass;
        pass_w = r_coll_trig || !r_active || i_contact_is_trigger;
        rx_w   = {r_vx[31], r_vx} - (r_dyn ? {r_vox[31], r_vox} : 33'sd0);
        ry_w   = {r_vy[31], r_vy} - (r_dyn ? {r_voy[31], r_voy} : 33'sd0);
        neg_van = 41'(-sh_acc);
    end

    // Sequencer: when a step finishes, pick the next one and its operands.
    always_comb begin
        is_mul   = r_state inside {S_CM, S_CMD, S_PX, S_PY, S_RX, S_RY,
                                   S_J, S_JM, S_VX, S_VY};
        is_div   = r_state inside {S_CMV, S_JV};
        done     = (is_mul && r_cnt == MulLast) || (is_div && r_cnt == DivLast);
        keep_acc = 1'b0;
        l_a      = '0;
        l_b      = '0;
        n_state  = r_state;
        case (r_state)
            S_IDLE: begin
                l_a = {10'd0, c_w};
                l_b = {17'd0, r_frac};
                n_state = S_CM;
            end
            S_CM: begin
                if (r_dyn) begin
                    l_a = {9'd0, n_acc[46:15]};
                    l_b = {2'd0, r_mo};
                    n_state = S_CMD;
                end else begin
                    l_a = {9'd0, n_acc[46:15]};
                    l_b = 33'(r_nx);
                    n_state = S_PX;
                end
            end
            S_CMD: n_state = S_CMV;
            S_CMV: begin
                l_a = {9'd0, n_q[31:0]};
                l_b = 33'(r_nx);
                n_state = S_PX;
            end
            S_PX: begin
                l_a = {9'd0, r_cm};
                l_b = 33'(r_ny);
                n_state = S_PY;
            end
            S_PY: begin
                l_a = 41'(rx_w);
                l_b = 33'(r_nx);
                n_state = S_RX;
            end
            S_RX: begin
                l_a = 41'(ry_w);
                l_b = 33'(r_ny);
                keep_acc = 1'b1;
                n_state = S_RY;
            end
            S_RY: begin
                if (!sh_acc[72] && sh_acc != '0) begin
                    n_state = S_OUT;
                end else begin
                    l_a = neg_van;
                    l_b = 33'({1'b0, r_restitution} + 17'd32768);
                    n_state = S_J;
                end
            end
            S_J: begin
                l_a = {4'd0, n_acc[51:15]};
                if (r_dyn) begin
                    l_b = {2'd0, r_mo};
                    n_state = S_JM;
                end else begin
                    l_b = 33'(r_nx);
                    n_state = S_VX;
                end
            end
            S_JM: n_state = S_JV;
            S_JV: begin
                l_a = {4'd0, n_q[36:0]};
                l_b = 33'(r_nx);
                n_state = S_VX;
            end
            S_VX: begin
                l_a = {4'd0, r_j};
                l_b = 33'(r_ny);
                n_state = S_VY;
            end
            S_VY: n_state = S_OUT;
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_body_mass   <= 31'd65536;
            r_restitution <= 16'd0;
            r_slop        <= 31'd655;
            r_frac        <= 16'd26214;
            r_coll_trig   <= 1'b0;
            r_active      <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BODY_MASS:   r_body_mass   <= i_cfg_data;
                REG_RESTITUTION: r_restitution <= i_cfg_data[15:0];
                REG_SLOP_DEPTH:  r_slop        <= i_cfg_data;
                REG_CORR_FRAC:   r_frac        <= i_cfg_data[15:0];
                REG_COLL_TRIG:   r_coll_trig   <= i_cfg_data[0];
                REG_BODY_ACTIVE: r_active      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Control state and body velocity.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_vx      <= '0;
            r_vy      <= '0;
            r_applied <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_applied <= 1'b0;
                        r_cnt     <= '0;
                        if (i_func == FUNC_LOAD) begin
                            r_vx    <= i_load_vel_x;
                            r_vy    <= i_load_vel_y;
                            r_state <= S_OUT;
                        end else if (pass_w) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= n_state;
                        end
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    if (done) begin
                        r_cnt   <= '0;
                        r_state <= n_state;
                        if (r_state == S_VX) begin
                            r_vx <= f_sat32({{42{r_vx[31]}}, r_vx} + {sh_acc[72], sh_acc});
                        end
                        if (r_state == S_VY) begin
                            r_vy <= f_sat32({{42{r_vy[31]}}, r_vy} + {sh_acc[72], sh_acc});
                            r_applied <= 1'b1;
                        end
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
            endcase
        end
    end

    // Datapath registers of the shared unit and the item.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_nx   <= i_normal_x;
            r_ny   <= i_normal_y;
            r_dyn  <= i_other_dynamic;
            r_mo   <= mo_w;
            r_msum <= {1'b0, m_w} + {1'b0, mo_w};
            r_vox  <= i_other_vel_x;
            r_voy  <= i_other_vel_y;
            r_pdx  <= '0;
            r_pdy  <= '0;
            r_ma   <= 73'(l_a);
            r_mb   <= l_b;
            r_acc  <= '0;
        end else if (is_mul) begin
            if (done) begin
                r_ma  <= 73'(l_a);
                r_mb  <= l_b;
                r_acc <= keep_acc ? n_acc : '0;
                if (r_state == S_CM)  r_cm  <= n_acc[46:15];
                if (r_state == S_J)   r_j   <= n_acc[51:15];
                if (r_state == S_PX)  r_pdx <= f_sat32({sh_acc[72], sh_acc});
                if (r_state == S_PY)  r_pdy <= f_sat32({sh_acc[72], sh_acc});
                if (r_state == S_CMD || r_state == S_JM) begin
                    r_dn  <= n_acc[68:0];
                    r_rem <= '0;
                    r_q   <= '0;
                end
            end else begin
                r_acc <= n_acc;
                r_ma  <= r_ma <<< 1;
                r_mb  <= r_mb >> 1;
            end
        end else if (is_div) begin
            r_rem <= n_rem;
            r_q   <= n_q;
            r_dn  <= {r_dn[67:0], 1'b0};
            if (done) begin
                r_ma  <= 73'(l_a);
                r_mb  <= l_b;
                r_acc <= '0;
                if (r_state == S_CMV) r_cm <= n_q[31:0];
                if (r_state == S_JV)  r_j  <= n_q[36:0];
            end
        end
    end

    // The block never offers a result while it can take an item.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready and valid together");

    // Step counter stays within the length of a running multiplier operation.
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_mul |-> r_cnt <= MulLast) else $error("multiplier count overrun");

    // A load item answers in the next cycle without an impulse.
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_func == FUNC_LOAD) |=> (o_valid && !o_impulse_applied))
        else $error("load item result missing");

    // A taken result returns the block to idle.
    a_ret: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |=> o_ready) else $error("no return to idle");

endmodule

`default_nettype wire
